// ===== design/pvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvm_pkg
// Shared types and constants for the PCM voice mixer.
// -----------------------------------------------------------------------------
package pvm_pkg;

  // Voice slots and sample store frames.
  localparam int MAX_VOICES   = 32;
  localparam int STORE_FRAMES = 65536;

  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_TRIGGER = 3'd1;
  localparam logic [2:0] KIND_STOP    = 3'd2;
  localparam logic [2:0] KIND_STOPALL = 3'd3;
  localparam logic [2:0] KIND_MIX     = 3'd4;

  localparam logic [1:0] REG_VOLUME = 2'd0;
  localparam logic [1:0] REG_ENABLE = 2'd1;
  localparam logic [1:0] REG_PAUSED = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  localparam logic [7:0] GAIN_ONE = 8'd128;
  localparam logic [5:0] DEFAULT_VOICES = 6'd8;

  // Voice record held in the voice memory.
  typedef struct packed {
    logic [15:0] base;
    logic [16:0] length;
    logic [16:0] position;
    logic [30:0] stamp;
  } voice_t;

  localparam int VOICE_W = $bits(voice_t);

  // Saturate a 18-bit signed sum to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    begin
      if (v > 18'sd32767) r = 16'sh7fff;
      else if (v < -18'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

  // Scale by gain/128, truncating toward zero.
  function automatic logic signed [15:0] scale(input logic signed [15:0] s,
                                               input logic [7:0] g);
    logic signed [24:0] p;
    logic signed [24:0] q;
    begin
      p = s * $signed({1'b0, g});
      q = p + ((p < 0) ? 25'sd127 : 25'sd0);
      return q[22:7];
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/pvm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pvm_ram
// Generic single-port RAM with registered read.
// -----------------------------------------------------------------------------
module pvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data shows in the next cycle.
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== design/pcm_voice_mixer_with_stealing_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcm_voice_mixer_with_stealing_top
// Stereo voice mixer with a sample store, a voice memory and a slot sweep.
// -----------------------------------------------------------------------------
// Each item is taken when start is high and busy is low and gives exactly one
// result: done is high for a single cycle, the first cycle after busy falls,
// and the receiver cannot stall it. A load, a stop-all, a trigger while
// disabled and a mix while disabled or paused go straight to the done state.
// A trigger reads one voice record per slot through the address, read and
// check states until it finds an idle slot or has seen voice_count slots, then
// writes the record. A stop by base checks all MAX_VOICES slots. A mix visits
// each slot below voice_count; for an active slot it reads the record and, if
// a sample remains, fetches the sample, adds it and writes back the advanced
// position. Configuration writes are taken only while the block is idle and
// no start is presented. Active flags sit in flip-flops, so reset needs no
// clearing pass.
module pcm_voice_mixer_with_stealing_top
  import pvm_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         kind,
  input  wire  [15:0]        address,
  input  wire  signed [15:0] sample_left,
  input  wire  signed [15:0] sample_right,
  input  wire  [16:0]        wave_length,
  input  wire  [30:0]        time_stamp,
  input  wire  signed [15:0] music_left,
  input  wire  signed [15:0] music_right,
  output logic               done,
  output logic signed [15:0] mix_left,
  output logic signed [15:0] mix_right,
  output logic [4:0]         voice_slot,
  output logic               accepted,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [1:0]         cfg_index,
  input  wire  [7:0]         cfg_data
);

  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int AW = $clog2(STORE_FRAMES);
  localparam int CW = $clog2(MAX_VOICES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN, S_SCAN_RD, S_SCAN_CHK, S_TRIG_WR,
    S_MIX_RD, S_MIX_CHK, S_MIX_SMP, S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [7:0]    volume;
  logic          enable;
  logic          pause;
  logic [CW-1:0] count;

  logic [MAX_VOICES-1:0] active;

  // Captured item.
  logic [2:0]         k;
  logic [15:0]        addr_q;
  logic [16:0]        len_q;
  logic [30:0]        ts_q;
  logic signed [15:0] acc_l, acc_r;

  // Sweep state.
  logic [CW-1:0] idx;
  logic [VW-1:0] best;
  logic [30:0]   best_ts;
  logic          steal_ok;
  voice_t        cur;

  // Memory ports.
  logic          v_we;
  logic [VW-1:0] v_addr;
  voice_t        v_wdata, v_rdata;
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic [31:0]   s_wdata, s_rdata;

  pvm_ram #(.WIDTH(VOICE_W), .DEPTH(1 << VW)) u_voice (
    .clk(clk), .we(v_we), .addr(v_addr), .wdata(v_wdata), .rdata(v_rdata)
  );

  pvm_ram #(.WIDTH(32), .DEPTH(STORE_FRAMES)) u_store (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
  );

  logic [7:0] gain;
  assign gain = (volume > GAIN_ONE) ? GAIN_ONE : volume;

  logic [CW-1:0] cfg_n;
  always_comb begin
    cfg_n = CW'(cfg_data[5:0]);
    if (cfg_data[5:0] == 6'd0) cfg_n = CW'(DEFAULT_VOICES);
    if ({2'b0, cfg_data[5:0]} > 8'(MAX_VOICES)) cfg_n = CW'(MAX_VOICES);
  end

  // Register writes land only between items.
  assign cfg_ready = (state == S_IDLE) && !start;
  assign busy = (state != S_IDLE);

  logic [VW-1:0] slot_i;
  assign slot_i = idx[VW-1:0];
  logic [16:0] pos_inc;
  assign pos_inc = cur.position + 17'd1;

  // Memory port control.
  always_comb begin
    v_we = 1'b0;
    v_addr = slot_i;
    v_wdata = cur;
    s_we = 1'b0;
    s_addr = AW'(addr_q);
    s_wdata = {sample_right, sample_left};
    case (state)
      S_IDLE: begin
        s_addr = AW'(address);
        s_we = start && (kind == KIND_LOAD);
      end
      S_TRIG_WR: begin
        v_we = 1'b1;
        v_addr = best;
        v_wdata = '{base: addr_q, length: len_q, position: 17'd0, stamp: ts_q};
      end
      S_MIX_CHK: begin
        s_addr = AW'(v_rdata.base + v_rdata.position[15:0]);
      end
      S_MIX_SMP: begin
        v_we = 1'b1;
        v_wdata.position = pos_inc;
      end
      default: ;
    endcase
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      volume <= GAIN_ONE;
      enable <= 1'b0;
      pause <= 1'b0;
      count <= CW'(DEFAULT_VOICES);
      active <= '0;
      done <= 1'b0;
      mix_left <= '0;
      mix_right <= '0;
      voice_slot <= '0;
      accepted <= 1'b0;
    end else begin
      done <= (state == S_TRIG_WR) || (state == S_DONE);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VOLUME: volume <= cfg_data;
          REG_ENABLE: begin
            enable <= cfg_data[0];
            if (!cfg_data[0]) active <= '0;
          end
          REG_PAUSED: pause <= cfg_data[0];
          REG_COUNT: begin
            count <= cfg_n;
            for (int i = 0; i < MAX_VOICES; i++)
              if (CW'(i) >= cfg_n) active[i] <= 1'b0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            k <= kind;
            addr_q <= address;
            len_q <= wave_length;
            ts_q <= time_stamp;
            acc_l <= music_left;
            acc_r <= music_right;
            idx <= '0;
            best <= '0;
            steal_ok <= 1'b0;
            case (kind)
              KIND_LOAD: state <= S_DONE;
              KIND_TRIGGER: state <= enable ? S_SCAN : S_DONE;
              KIND_STOP: state <= S_SCAN;
              KIND_STOPALL: begin
                active <= '0;
                state <= S_DONE;
              end
              KIND_MIX: state <= (enable && !pause) ? S_MIX_RD : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        // Trigger and stop: visit each slot's record.
        S_SCAN: state <= S_SCAN_RD;
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (k == KIND_STOP) begin
            if (v_rdata.base == addr_q) active[slot_i] <= 1'b0;
            if (idx == CW'(MAX_VOICES - 1)) state <= S_DONE;
            else begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end
          end else if (!active[slot_i]) begin
            // The first idle slot takes the trigger.
            best <= slot_i;
            state <= S_TRIG_WR;
          end else begin
            // Track the oldest voice; the lowest slot wins ties.
            if (!steal_ok || v_rdata.stamp < best_ts) begin
              best <= slot_i;
              best_ts <= v_rdata.stamp;
              steal_ok <= 1'b1;
            end
            if (idx == count - 1'b1) state <= S_TRIG_WR;
            else begin
              idx <= idx + 1'b1;
              state <= S_SCAN;
            end
          end
        end
        S_TRIG_WR: begin
          active[best] <= 1'b1;
          voice_slot <= 5'(best);
          accepted <= 1'b1;
          mix_left <= '0;
          mix_right <= '0;
          state <= S_IDLE;
        end
        // Mix: read a record, fetch its sample, update position.
        S_MIX_RD: begin
          if (idx == count) state <= S_DONE;
          else if (!active[slot_i]) idx <= idx + 1'b1;
          else state <= S_MIX_CHK;
        end
        S_MIX_CHK: begin
          cur <= v_rdata;
          if (v_rdata.position < v_rdata.length) state <= S_MIX_SMP;
          else begin
            active[slot_i] <= 1'b0;
            idx <= idx + 1'b1;
            state <= S_MIX_RD;
          end
        end
        S_MIX_SMP: begin
          acc_l <= sat16(18'(acc_l) + 18'(scale(s_rdata[15:0], gain)));
          acc_r <= sat16(18'(acc_r) + 18'(scale(s_rdata[31:16], gain)));
          if (pos_inc >= cur.length) active[slot_i] <= 1'b0;
          idx <= idx + 1'b1;
          state <= S_MIX_RD;
        end
        S_DONE: begin
          mix_left <= (k == KIND_MIX) ? acc_l : 16'sd0;
          mix_right <= (k == KIND_MIX) ? acc_r : 16'sd0;
          voice_slot <= '0;
          accepted <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result strobe is a single cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for two cycles");
  // A trigger result always comes with a slot below the voice count.
  assert property (@(posedge clk) disable iff (rst)
    (done && accepted) |-> ({1'b0, voice_slot} < 6'(count)))
    else $error("slot beyond voice count");
  // No busy without a start while idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !start) |=> !busy)
    else $error("busy without item");

endmodule
`default_nettype wire
